// ===== rtl/core/tiun_pkg.sv =====
package tiun_pkg;

    localparam int COORD_WIDTH_DEF = 32;

    // normalised magnitude window and its square
    localparam int Q_W  = 31;
    localparam int SQ_W = 2 * Q_W;
    localparam int S2_W = 64;

    // integer square root: one result bit per stage
    localparam int ROOT_W     = 32;
    localparam int ROOT_STEPS = 32;

    // restoring divider: one quotient bit per stage
    localparam int QUO_W = 31;
    localparam int DIV_W = 64;

    localparam int NORM_W = 32;
    localparam logic [QUO_W-1:0]         QUO_ONE   = QUO_W'(1) << 30;
    localparam logic signed [NORM_W-1:0] NORM_ONE  = 32'sh4000_0000;
    localparam logic signed [NORM_W-1:0] NORM_HALF = 32'sh2000_0000;

    typedef struct packed {
        logic [2:0][Q_W-1:0] q;
        logic [2:0]          neg;
        logic                degen;
    } tiun_side_t;

endpackage

// ===== rtl/core/tiun_cross.sv =====
module tiun_cross
    import tiun_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [2:0][COORD_WIDTH-1:0]       v0,
    input  logic [2:0][COORD_WIDTH-1:0]       v1,
    input  logic [2:0][COORD_WIDTH-1:0]       v2,
    input  logic [2:0][COORD_WIDTH-1:0]       ct,
    output logic                              out_valid,
    output logic [2:0][2*COORD_WIDTH+2:0]     c,
    output logic [2:0][COORD_WIDTH:0]         e
);

    localparam int DW  = COORD_WIDTH + 1;
    localparam int PW  = 2 * DW;
    localparam int CPW = PW + 1;

    logic [2:0]          vld_reg;
    logic [2:0][DW-1:0]  a_reg, b_reg, e1_reg, e2_reg, e3_reg;
    logic [2:0][DW-1:0]  a_next, b_next, e1_next;
    logic [5:0][PW-1:0]  p_reg, p_next;
    logic [2:0][CPW-1:0] c_reg, c_next;

    // edge vectors and centroid offset, exact
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            a_next[i]  = {v0[i][COORD_WIDTH-1], v0[i]} - {v1[i][COORD_WIDTH-1], v1[i]};
            b_next[i]  = {v0[i][COORD_WIDTH-1], v0[i]} - {v2[i][COORD_WIDTH-1], v2[i]};
            e1_next[i] = {ct[i][COORD_WIDTH-1], ct[i]} - {v0[i][COORD_WIDTH-1], v0[i]};
        end
    end

    // cross product partials: a1b2 a2b1 a2b0 a0b2 a0b1 a1b0
    always_comb begin
        p_next[0] = PW'($signed(a_reg[1])) * PW'($signed(b_reg[2]));
        p_next[1] = PW'($signed(a_reg[2])) * PW'($signed(b_reg[1]));
        p_next[2] = PW'($signed(a_reg[2])) * PW'($signed(b_reg[0]));
        p_next[3] = PW'($signed(a_reg[0])) * PW'($signed(b_reg[2]));
        p_next[4] = PW'($signed(a_reg[0])) * PW'($signed(b_reg[1]));
        p_next[5] = PW'($signed(a_reg[1])) * PW'($signed(b_reg[0]));
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_next[i] = CPW'($signed(p_reg[2*i])) - CPW'($signed(p_reg[2*i+1]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg  <= a_next;
            b_reg  <= b_next;
            e1_reg <= e1_next;
            p_reg  <= p_next;
            e2_reg <= e1_reg;
            c_reg  <= c_next;
            e3_reg <= e2_reg;
        end
    end

    assign out_valid = vld_reg[2];
    assign c         = c_reg;
    assign e         = e3_reg;

endmodule

// ===== rtl/core/tiun_orient.sv =====
module tiun_orient
    import tiun_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [2:0][2*COORD_WIDTH+2:0] c,
    input  logic [2:0][COORD_WIDTH:0]     e,
    output logic                          out_valid,
    output logic [S2_W-1:0]               s2,
    output tiun_side_t                    side
);

    localparam int DW  = COORD_WIDTH + 1;
    localparam int CPW = 2 * DW + 1;
    // cross component split into an unsigned low part and a signed high part
    localparam int H   = COORD_WIDTH + 2;
    localparam int HW  = CPW - H;
    localparam int LPW = H + 1 + DW;
    localparam int HPW = HW + DW;
    localparam int DSW = 3 * COORD_WIDTH + 6;
    localparam int BLW = $clog2(CPW + 1);

    logic [4:0] vld_reg;

    // stage 4
    logic [2:0][CPW-1:0]   mag4_reg, mag4_next;
    logic [2:0]            sgn4_reg;
    logic                  zero4_reg, zero4_next;
    logic [2:0][LPW-1:0]   lp4_reg, lp4_next;
    logic [2:0][HPW-1:0]   hp4_reg, hp4_next;
    logic signed [H:0]     lo_w [3];

    // stage 5
    logic [DSW-1:0]        plane_d;
    logic [CPW-1:0]        or_w;
    logic [BLW-1:0]        bl_next, bl5_reg;
    logic [2:0][CPW-1:0]   mag5_reg;
    logic [2:0]            neg5_reg;
    logic                  zero5_reg;

    // stage 6
    logic [2:0][Q_W-1:0]   q6_reg, q6_next;
    logic [BLW-1:0]        shr, shl;
    logic [2:0]            neg6_reg;
    logic                  zero6_reg;

    // stages 7 and 8
    logic [2:0][SQ_W-1:0]  sq7_reg;
    tiun_side_t            side7_reg, side8_reg;
    logic [S2_W-1:0]       s2_reg;

    always_comb begin
        zero4_next = 1'b1;
        for (int i = 0; i < 3; i++) begin
            mag4_next[i] = c[i][CPW-1] ? (~c[i] + 1'b1) : c[i];
            if (c[i] != '0) begin
                zero4_next = 1'b0;
            end
            lo_w[i]     = {1'b0, c[i][H-1:0]};
            lp4_next[i] = LPW'(lo_w[i]) * LPW'($signed(e[i]));
            hp4_next[i] = HPW'($signed(c[i][CPW-1:H])) * HPW'($signed(e[i]));
        end
    end

    // signed distance, exact; only its sign is kept
    always_comb begin
        plane_d = '0;
        for (int i = 0; i < 3; i++) begin
            plane_d = plane_d + (DSW'($signed(hp4_reg[i])) << H) + DSW'($signed(lp4_reg[i]));
        end
    end

    // bit length of the largest magnitude
    always_comb begin
        or_w    = mag4_reg[0] | mag4_reg[1] | mag4_reg[2];
        bl_next = '0;
        for (int b = 0; b < CPW; b++) begin
            if (or_w[b]) begin
                bl_next = BLW'(b + 1);
            end
        end
    end

    always_comb begin
        shr = bl5_reg - BLW'(Q_W);
        shl = BLW'(Q_W) - bl5_reg;
        for (int i = 0; i < 3; i++) begin
            if (bl5_reg >= BLW'(Q_W)) begin
                q6_next[i] = Q_W'(mag5_reg[i] >> shr);
            end else begin
                q6_next[i] = Q_W'(mag5_reg[i] << shl);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag4_reg  <= mag4_next;
            sgn4_reg  <= {c[2][CPW-1], c[1][CPW-1], c[0][CPW-1]};
            zero4_reg <= zero4_next;
            lp4_reg   <= lp4_next;
            hp4_reg   <= hp4_next;

            mag5_reg  <= mag4_reg;
            neg5_reg  <= sgn4_reg ^ {3{plane_d[DSW-1]}};
            zero5_reg <= zero4_reg;
            bl5_reg   <= bl_next;

            q6_reg    <= q6_next;
            neg6_reg  <= neg5_reg;
            zero6_reg <= zero5_reg;

            for (int i = 0; i < 3; i++) begin
                sq7_reg[i] <= SQ_W'(q6_reg[i]) * SQ_W'(q6_reg[i]);
            end
            side7_reg <= '{q: q6_reg, neg: neg6_reg, degen: zero6_reg};

            s2_reg    <= S2_W'(sq7_reg[0]) + S2_W'(sq7_reg[1]) + S2_W'(sq7_reg[2]);
            side8_reg <= side7_reg;
        end
    end

    assign out_valid = vld_reg[4];
    assign s2        = s2_reg;
    assign side      = side8_reg;

endmodule

// ===== rtl/core/tiun_sqrt.sv =====
module tiun_sqrt
    import tiun_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [S2_W-1:0]   s2,
    input  tiun_side_t        side_in,
    output logic              out_valid,
    output logic [ROOT_W-1:0] root,
    output tiun_side_t        side_out
);

    logic [ROOT_STEPS-1:0] vld_reg;
    logic [S2_W-1:0]       rem_reg  [ROOT_STEPS];
    logic [S2_W-1:0]       res_reg  [ROOT_STEPS];
    tiun_side_t            side_reg [ROOT_STEPS];

    logic [S2_W-1:0]       rem_cur  [ROOT_STEPS];
    logic [S2_W-1:0]       res_cur  [ROOT_STEPS];
    tiun_side_t            side_cur [ROOT_STEPS];
    logic [S2_W-1:0]       rem_next [ROOT_STEPS];
    logic [S2_W-1:0]       res_next [ROOT_STEPS];
    logic [S2_W-1:0]       trial    [ROOT_STEPS];
    logic [S2_W-1:0]       bitv     [ROOT_STEPS];

    always_comb begin
        rem_cur[0]  = s2;
        res_cur[0]  = '0;
        side_cur[0] = side_in;
        for (int k = 1; k < ROOT_STEPS; k++) begin
            rem_cur[k]  = rem_reg[k-1];
            res_cur[k]  = res_reg[k-1];
            side_cur[k] = side_reg[k-1];
        end
    end

    // digit-by-digit root, test bit walks down two places per stage
    always_comb begin
        for (int k = 0; k < ROOT_STEPS; k++) begin
            bitv[k]  = S2_W'(1) << (S2_W - 2 - 2 * k);
            trial[k] = res_cur[k] + bitv[k];
            if (rem_cur[k] >= trial[k]) begin
                rem_next[k] = rem_cur[k] - trial[k];
                res_next[k] = (res_cur[k] >> 1) + bitv[k];
            end else begin
                rem_next[k] = rem_cur[k];
                res_next[k] = res_cur[k] >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[ROOT_STEPS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < ROOT_STEPS; k++) begin
                rem_reg[k]  <= rem_next[k];
                res_reg[k]  <= res_next[k];
                side_reg[k] <= side_cur[k];
            end
        end
    end

    assign out_valid = vld_reg[ROOT_STEPS-1];
    assign root      = ROOT_W'(res_reg[ROOT_STEPS-1]);
    assign side_out  = side_reg[ROOT_STEPS-1];

endmodule

// ===== rtl/core/tiun_div.sv =====
module tiun_div
    import tiun_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [ROOT_W-1:0]      root,
    input  tiun_side_t             side_in,
    output logic                   out_valid,
    output logic [2:0][NORM_W-1:0] normal,
    output logic                   degenerate
);

    logic [QUO_W-1:0]          vld_reg;
    logic [2:0][DIV_W-1:0]     rem_reg  [QUO_W];
    logic [2:0][QUO_W-1:0]     quo_reg  [QUO_W];
    logic [ROOT_W:0]           dvs_reg  [QUO_W];
    tiun_side_t                side_reg [QUO_W];

    logic [2:0][DIV_W-1:0]     rem_cur  [QUO_W];
    logic [2:0][QUO_W-1:0]     quo_cur  [QUO_W];
    logic [ROOT_W:0]           dvs_cur  [QUO_W];
    tiun_side_t                side_cur [QUO_W];
    logic [2:0][DIV_W-1:0]     rem_next [QUO_W];
    logic [2:0][QUO_W-1:0]     quo_next [QUO_W];
    logic [DIV_W-1:0]          dsh      [QUO_W];

    logic [ROOT_W-1:0]         root_cl;
    logic [2:0][QUO_W-1:0]     mag_out;
    logic [2:0][NORM_W-1:0]    norm_next, norm_reg;
    logic                      out_vld_reg, degen_reg;

    // numerator q*2^31 + r over divisor 2r rounds q*2^30/r half up
    always_comb begin
        root_cl     = (root == '0) ? ROOT_W'(1) : root;
        dvs_cur[0]  = {root_cl, 1'b0};
        side_cur[0] = side_in;
        quo_cur[0]  = '0;
        for (int j = 0; j < 3; j++) begin
            rem_cur[0][j] = (DIV_W'(side_in.q[j]) << 31) + DIV_W'(root_cl);
        end
        for (int k = 1; k < QUO_W; k++) begin
            rem_cur[k]  = rem_reg[k-1];
            quo_cur[k]  = quo_reg[k-1];
            dvs_cur[k]  = dvs_reg[k-1];
            side_cur[k] = side_reg[k-1];
        end
    end

    always_comb begin
        for (int k = 0; k < QUO_W; k++) begin
            dsh[k] = DIV_W'(dvs_cur[k]) << (QUO_W - 1 - k);
            for (int j = 0; j < 3; j++) begin
                if (rem_cur[k][j] >= dsh[k]) begin
                    rem_next[k][j] = rem_cur[k][j] - dsh[k];
                    quo_next[k][j] = {quo_cur[k][j][QUO_W-2:0], 1'b1};
                end else begin
                    rem_next[k][j] = rem_cur[k][j];
                    quo_next[k][j] = {quo_cur[k][j][QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            mag_out[j] = (quo_reg[QUO_W-1][j] > QUO_ONE) ? QUO_ONE : quo_reg[QUO_W-1][j];
            if (side_reg[QUO_W-1].degen) begin
                norm_next[j] = '0;
            end else if (side_reg[QUO_W-1].neg[j]) begin
                norm_next[j] = -NORM_W'(mag_out[j]);
            end else begin
                norm_next[j] = NORM_W'(mag_out[j]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[QUO_W-2:0], in_valid};
            out_vld_reg <= vld_reg[QUO_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < QUO_W; k++) begin
                rem_reg[k]  <= rem_next[k];
                quo_reg[k]  <= quo_next[k];
                dvs_reg[k]  <= dvs_cur[k];
                side_reg[k] <= side_cur[k];
            end
            norm_reg  <= norm_next;
            degen_reg <= side_reg[QUO_W-1].degen;
        end
    end

    assign out_valid  = out_vld_reg;
    assign normal     = norm_reg;
    assign degenerate = degen_reg;

endmodule

// ===== rtl/core/triangle_inward_unit_normal_core.sv =====
// Inward unit normal of a triangle. Each item carries three vertices and the centroid of the
// element the triangle bounds (signed Q16.16, low COORD_WIDTH bits used); the result is the
// cross product (v0-v1) x (v0-v2) scaled to unit length in signed Q2.30, negated when the
// centroid lies below the plane, or zero with m_degenerate set when the cross product is zero.
// One item is accepted every cycle unless the pipeline holds. An item passes, in order, the
// exact cross product; orientation, normalising shift and sum of squares; the square root (one
// root bit per stage); the three parallel dividers (one quotient bit per stage); and an output
// register. The whole pipeline holds while a result waits on m_ready.
module triangle_inward_unit_normal_core
    import tiun_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [COORD_WIDTH-1:0] s_v0_x,
    input  logic [COORD_WIDTH-1:0] s_v0_y,
    input  logic [COORD_WIDTH-1:0] s_v0_z,
    input  logic [COORD_WIDTH-1:0] s_v1_x,
    input  logic [COORD_WIDTH-1:0] s_v1_y,
    input  logic [COORD_WIDTH-1:0] s_v1_z,
    input  logic [COORD_WIDTH-1:0] s_v2_x,
    input  logic [COORD_WIDTH-1:0] s_v2_y,
    input  logic [COORD_WIDTH-1:0] s_v2_z,
    input  logic [COORD_WIDTH-1:0] s_centroid_x,
    input  logic [COORD_WIDTH-1:0] s_centroid_y,
    input  logic [COORD_WIDTH-1:0] s_centroid_z,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [NORM_W-1:0]      m_normal_x,
    output logic [NORM_W-1:0]      m_normal_y,
    output logic [NORM_W-1:0]      m_normal_z,
    output logic                   m_degenerate
);

    logic                          adv;
    logic                          cross_vld, orient_vld, sqrt_vld;
    logic [2:0][2*COORD_WIDTH+2:0] cross_c;
    logic [2:0][COORD_WIDTH:0]     cross_e;
    logic [S2_W-1:0]               sum_sq;
    tiun_side_t                    orient_side, sqrt_side;
    logic [ROOT_W-1:0]             root;
    logic [2:0][NORM_W-1:0]        normal;

    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    tiun_cross #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_cross (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_valid (s_valid),
        .v0       ({s_v0_z, s_v0_y, s_v0_x}),
        .v1       ({s_v1_z, s_v1_y, s_v1_x}),
        .v2       ({s_v2_z, s_v2_y, s_v2_x}),
        .ct       ({s_centroid_z, s_centroid_y, s_centroid_x}),
        .out_valid(cross_vld),
        .c        (cross_c),
        .e        (cross_e)
    );

    tiun_orient #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_orient (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_valid (cross_vld),
        .c        (cross_c),
        .e        (cross_e),
        .out_valid(orient_vld),
        .s2       (sum_sq),
        .side     (orient_side)
    );

    tiun_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_valid (orient_vld),
        .s2       (sum_sq),
        .side_in  (orient_side),
        .out_valid(sqrt_vld),
        .root     (root),
        .side_out (sqrt_side)
    );

    tiun_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (sqrt_vld),
        .root      (root),
        .side_in   (sqrt_side),
        .out_valid (m_valid),
        .normal    (normal),
        .degenerate(m_degenerate)
    );

    assign m_normal_x = normal[0];
    assign m_normal_y = normal[1];
    assign m_normal_z = normal[2];

`ifndef NO_ASSERTIONS
    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |->
            (m_normal_x == '0) && (m_normal_y == '0) && (m_normal_z == '0))
        else $error("degenerate item with non-zero normal");

    a_unit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |->
            ($signed(m_normal_x) <= NORM_ONE) && ($signed(m_normal_x) >= -NORM_ONE) &&
            ($signed(m_normal_y) <= NORM_ONE) && ($signed(m_normal_y) >= -NORM_ONE) &&
            ($signed(m_normal_z) <= NORM_ONE) && ($signed(m_normal_z) >= -NORM_ONE))
        else $error("normal component beyond unit");

    // a unit vector always has one component of magnitude at least 1/sqrt(3)
    a_unit_min: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_degenerate |->
            ($signed(m_normal_x) >= NORM_HALF) || ($signed(m_normal_x) <= -NORM_HALF) ||
            ($signed(m_normal_y) >= NORM_HALF) || ($signed(m_normal_y) <= -NORM_HALF) ||
            ($signed(m_normal_z) >= NORM_HALF) || ($signed(m_normal_z) <= -NORM_HALF))
        else $error("non-degenerate normal too short");
`endif

endmodule

// ===== bench/tb_triangle_inward_unit_normal_core.sv =====
module tb_triangle_inward_unit_normal_core
    import tiun_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW        = COORD_WIDTH_DEF;
    localparam int N_RANDOM  = 800;
    localparam int CYC_LIMIT = 400000;
    localparam int DRAIN     = 100;

    typedef logic signed [31:0] coord_t;

    typedef struct {
        logic [NORM_W-1:0] nx;
        logic [NORM_W-1:0] ny;
        logic [NORM_W-1:0] nz;
        logic              degen;
    } normal_t;

    // inward unit normal as the core computes it, widths sized so nothing overflows
    function automatic normal_t inward_normal(coord_t v[12]);
        logic signed [47:0]  crd [12];
        logic signed [48:0]  a [3], b [3], e [3];
        logic signed [99:0]  c [3];
        logic signed [159:0] plane_d;
        logic [99:0]         mag [3];
        logic [63:0]         q [3];
        logic [63:0]         s2, r, rem, bit_v, n;
        logic                flip;
        int                  m, sh;
        normal_t             res;
        for (int i = 0; i < 12; i++) crd[i] = 48'(signed'(v[i][CW-1:0]));
        for (int i = 0; i < 3; i++) begin
            a[i] = crd[i] - crd[3 + i];
            b[i] = crd[i] - crd[6 + i];
            e[i] = crd[9 + i] - crd[i];
        end
        c[0] = 100'(a[1]) * b[2] - 100'(a[2]) * b[1];
        c[1] = 100'(a[2]) * b[0] - 100'(a[0]) * b[2];
        c[2] = 100'(a[0]) * b[1] - 100'(a[1]) * b[0];
        if (c[0] == 0 && c[1] == 0 && c[2] == 0) begin
            res = '{0, 0, 0, 1'b1};
            return res;
        end
        plane_d = 160'(c[0]) * e[0] + 160'(c[1]) * e[1] + 160'(c[2]) * e[2];
        flip = plane_d < 0;
        m = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = c[i] < 0 ? 100'(-c[i]) : 100'(c[i]);
            for (int k = 99; k >= 0; k--) if (mag[i][k]) begin
                if (k + 1 > m) m = k + 1;
                break;
            end
        end
        sh = m - 31;
        s2 = 0;
        for (int i = 0; i < 3; i++) begin
            if (sh >= 0) q[i] = 64'(mag[i] >> sh) & 64'h7FFF_FFFF;
            else         q[i] = (64'(mag[i]) << (-sh)) & 64'h7FFF_FFFF;
            s2 += q[i] * q[i];
        end
        r = 0; rem = s2; bit_v = 64'd1 << 62;
        while (bit_v > rem) bit_v >>= 2;
        while (bit_v != 0) begin
            if (rem >= r + bit_v) begin
                rem -= r + bit_v;
                r = (r >> 1) + bit_v;
            end else r >>= 1;
            bit_v >>= 2;
        end
        if (r == 0) r = 1;
        for (int i = 0; i < 3; i++) begin
            n = ((q[i] << 31) + r) / (2 * r);
            if (n > (64'd1 << 30)) n = 64'd1 << 30;
            n = ((c[i] < 0) != flip) ? -n : n;
            if (i == 0) res.nx = n[31:0];
            else if (i == 1) res.ny = n[31:0];
            else res.nz = n[31:0];
        end
        res.degen = 1'b0;
        return res;
    endfunction

    class normal_scoreboard;
        normal_t pending[$];
        int      errors;

        function void note_triangle(coord_t v[12]);
            pending.push_back(inward_normal(v));
        endfunction

        function void check_normal(normal_t got);
            normal_t exp_n;
            if (pending.size() == 0) begin
                $error("result item with nothing expected");
                errors++;
                return;
            end
            exp_n = pending.pop_front();
            if (got.nx !== exp_n.nx) begin
                $error("normal_x exp %h got %h", exp_n.nx, got.nx); errors++;
            end
            if (got.ny !== exp_n.ny) begin
                $error("normal_y exp %h got %h", exp_n.ny, got.ny); errors++;
            end
            if (got.nz !== exp_n.nz) begin
                $error("normal_z exp %h got %h", exp_n.nz, got.nz); errors++;
            end
            if (got.degen !== exp_n.degen) begin
                $error("degenerate exp %b got %b", exp_n.degen, got.degen); errors++;
            end
        endfunction
    endclass

    logic aclk, aresetn;
    logic s_valid, s_ready, m_valid, m_ready;
    logic [CW-1:0] s_c [12];
    logic [NORM_W-1:0] m_normal_x, m_normal_y, m_normal_z;
    logic m_degenerate;

    normal_scoreboard sb = new();
    int  cycles;
    bit  stim_done, hold_off;

    triangle_inward_unit_normal_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_v0_x(s_c[0]), .s_v0_y(s_c[1]), .s_v0_z(s_c[2]),
        .s_v1_x(s_c[3]), .s_v1_y(s_c[4]), .s_v1_z(s_c[5]),
        .s_v2_x(s_c[6]), .s_v2_y(s_c[7]), .s_v2_z(s_c[8]),
        .s_centroid_x(s_c[9]), .s_centroid_y(s_c[10]), .s_centroid_z(s_c[11]),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_normal_x(m_normal_x), .m_normal_y(m_normal_y), .m_normal_z(m_normal_z),
        .m_degenerate(m_degenerate)
    );

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        aresetn = 0; s_valid = 0; m_ready = 0; hold_off = 0;
        for (int i = 0; i < 12; i++) s_c[i] = '0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int gap_len();
        if ($urandom_range(0, 99) < 3) return $urandom_range(20, 120);
        if ($urandom_range(0, 99) < 50) return 0;
        return $urandom_range(0, 3);
    endfunction

    function automatic coord_t rand_coord(int style);
        case (style)
            0: return $urandom();
            1: return $signed($urandom_range(0, 2047)) - 1024;
            2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
        endcase
    endfunction

    // valid stays up between back-to-back items and drops only for a gap
    task automatic send_triangle(coord_t v[12]);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        for (int i = 0; i < 12; i++) s_c[i] <= v[i];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_triangle(v);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int g;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                sb.check_normal('{m_normal_x, m_normal_y, m_normal_z, m_degenerate});
            if (hold_off) begin
                m_ready <= 1'b0;
                for (int k = 0; k < 300; k++) @(posedge aclk);
                hold_off = 0;
                continue;
            end
            g = gap_len();
            if (g > 0) begin
                m_ready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    initial begin
        coord_t v[12];
        int style;
        cycles = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: unit triangle, centroid above / below / on plane
        v = '{0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000};
        send_triangle(v);
        v[11] = -32'sh10000; send_triangle(v);
        v[11] = 0; send_triangle(v);
        // collinear and coincident points
        v = '{0, 0, 0, 1, 1, 1, 2, 2, 2, 5, 6, 7}; send_triangle(v);
        v = '{7, 7, 7, 7, 7, 7, 7, 7, 7, 0, 0, 0}; send_triangle(v);
        // extremes of the coordinate range
        for (int i = 0; i < 12; i++) v[i] = 32'sh8000_0000;
        v[3] = 32'sh7FFF_FFFF; v[7] = 32'sh7FFF_FFFF; send_triangle(v);
        for (int i = 0; i < 12; i++) v[i] = 32'sh7FFF_FFFF;
        v[3] = 32'sh8000_0000; v[7] = 32'sh8000_0000; v[11] = 32'sh8000_0000;
        send_triangle(v);
        v = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, -1}; send_triangle(v);
        v = '{-1, -1, -1, 0, 0, 0, 1, 2, 3, 9, 9, 9}; send_triangle(v);
        v = '{0, 0, 0, 32'sh7FFF_FFFF, 0, 0, 0, 1, 0, 0, 0, 5}; send_triangle(v);
        for (int i = 0; i < 12; i++) v[i] = -1;
        send_triangle(v);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 300) hold_off = 1;
            style = $urandom_range(0, 3);
            for (int i = 0; i < 12; i++) v[i] = rand_coord(style);
            if ($urandom_range(0, 15) == 0) begin
                // degenerate: v2 on the line through v0 and v1
                for (int i = 0; i < 3; i++) v[6 + i] = v[i] + (v[i] - v[3 + i]);
            end else if ($urandom_range(0, 15) == 0) begin
                for (int i = 0; i < 3; i++) v[9 + i] = v[i];
            end
            send_triangle(v);
        end
        s_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
